### rtl/sswn_pkg.sv
package sswn_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned OUT_W       = 80;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RD_MID  = 2'd0,
    RD_IDX  = 2'd1,
    RD_PREV = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    clear;
    logic    start;
    logic    step;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    set_found;
    logic    set_upper;
    logic    set_lower;
    logic    do_append;
    logic    load_append;
    logic    load_query;
  } cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic idx_lt_cnt;
    logic idx_nz;
    logic rd_eq;
    logic rd_below;
    logic slot_free;
  } sts_t;

endpackage

### rtl/sorted_search_with_neighbors_top.sv
// Sorted table search with nearest neighbors.
// Input stream: s_axis_tuser_i carries the opcode (clear, append, query) and
// s_axis_tdata_i the 32-bit signed value. A transaction is taken when
// s_axis_tvalid_i and s_axis_tready_o are both high; one is handled at a time.
// Clear resets the entry count at the edge it is taken and gives no result.
// Append writes the next entry (or flags overflow when full) and gives one
// result, loaded from the append state once the output register is free.
// Query gives one result: found with the 1-based position of the first equal
// entry, or the nearest lower and upper entries with valid bits.
// While every entry appended since the last clear has been in non-descending
// order, a query is a binary search; each step reads through the registered
// memory read port, then compares. Once an entry out of order is appended,
// queries scan in load order, reading and comparing each entry examined; the
// lower and upper entries are those either side of where it stops, not nearest.
// After a result is loaded the block returns to idle, where it takes the
// next transaction.
// Results sit in an output register; while the receiver stalls the next
// transaction can still be taken and worked on up to its result.
// Reset empties the table; no clearing pass is needed.
module sorted_search_with_neighbors_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // value
  input  logic [1:0]  s_axis_tuser_i,  // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // found, position[11], lower_value[32], lower_valid, upper_value[32],
  // upper_valid, overflow, zero pad
  output logic [79:0] m_axis_tdata_o
);
  import sswn_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             found;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] lower_value, upper_value;
  logic             lower_valid, upper_valid, overflow;

  sswn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_op_i    (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sswn_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_value_i     (s_axis_tdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_ready_i     (m_axis_tready_i),
    .m_valid_o     (m_axis_tvalid_o),
    .found_o       (found),
    .position_o    (position),
    .lower_value_o (lower_value),
    .lower_valid_o (lower_valid),
    .upper_value_o (upper_value),
    .upper_valid_o (upper_valid),
    .overflow_o    (overflow)
  );

  assign m_axis_tdata_o = {1'b0, overflow, upper_valid, upper_value,
                           lower_valid, lower_value, position, found};

endmodule

### rtl/sswn_ctrl.sv
module sswn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic [1:0]    s_op_i,
  output logic          s_ready_o,
  input  sswn_pkg::sts_t sts_i,
  output sswn_pkg::cmd_t cmd_o
);
  import sswn_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_APPEND   = 9'b000000010,
    ST_SRCH_RD  = 9'b000000100,
    ST_SRCH_CMP = 9'b000001000,
    ST_UP_RD    = 9'b000010000,
    ST_UP_CMP   = 9'b000100000,
    ST_LO_RD    = 9'b001000000,
    ST_LO_CMP   = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i & s_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_MID;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          case (op_e'(s_op_i))
            OP_CLEAR:  cmd_o.clear = 1'b1;
            OP_APPEND: state_d = ST_APPEND;
            OP_QUERY: begin
              cmd_o.start = 1'b1;
              state_d     = ST_SRCH_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_APPEND: begin
        if (sts_i.slot_free) begin
          cmd_o.do_append   = 1'b1;
          cmd_o.load_append = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_MID;
          state_d      = ST_SRCH_CMP;
        end else begin
          state_d = ST_UP_RD;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_SRCH_RD;
      end
      ST_UP_RD: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = ST_UP_CMP;
        end else begin
          state_d = ST_LO_RD;
        end
      end
      ST_UP_CMP: begin
        if (sts_i.rd_eq) begin
          cmd_o.set_found = 1'b1;
          state_d         = ST_OUT;
        end else begin
          cmd_o.set_upper = 1'b1;
          state_d         = ST_LO_RD;
        end
      end
      ST_LO_RD: begin
        if (sts_i.idx_nz) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = ST_LO_CMP;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_LO_CMP: begin
        cmd_o.set_lower = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.load_query = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/sswn_dp.sv
module sswn_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sswn_pkg::VAL_W-1:0]    s_value_i,
  input  sswn_pkg::cmd_t                cmd_i,
  output sswn_pkg::sts_t                sts_o,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic                          found_o,
  output logic [sswn_pkg::POS_W-1:0]    position_o,
  output logic [sswn_pkg::VAL_W-1:0]    lower_value_o,
  output logic                          lower_valid_o,
  output logic [sswn_pkg::VAL_W-1:0]    upper_value_o,
  output logic                          upper_valid_o,
  output logic                          overflow_o
);
  import sswn_pkg::*;

  logic [VAL_W-1:0]  mem_q [TABLE_DEPTH];
  logic [VAL_W-1:0]  rdata_q;
  logic [ADDR_W-1:0] rd_addr;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              sorted_q, sorted_d;
  logic [VAL_W-1:0]  last_q;
  logic [VAL_W-1:0]  val_q;
  logic [CNT_W-1:0]  lo_q, hi_q;
  logic              lin_q;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  prev;
  logic [CNT_W:0]    pos_sum;
  logic              full;

  logic              res_found_q;
  logic [POS_W-1:0]  res_pos_q;
  logic [VAL_W-1:0]  res_lower_q, res_upper_q;
  logic              res_lower_vld_q, res_upper_vld_q;

  logic              out_valid_q, out_valid_d;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = lin_q ? lo_q : mid_sum[CNT_W:1];
  assign prev    = lo_q - CNT_W'(1);
  assign pos_sum = {1'b0, lo_q} + (CNT_W+1)'(1);
  assign full    = (cnt_q == CNT_W'(TABLE_DEPTH));

  always_comb begin
    case (cmd_i.rd_sel)
      RD_MID:  rd_addr = mid[ADDR_W-1:0];
      RD_IDX:  rd_addr = lo_q[ADDR_W-1:0];
      RD_PREV: rd_addr = prev[ADDR_W-1:0];
      default: rd_addr = mid[ADDR_W-1:0];
    endcase
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_append && !full) begin
      mem_q[cnt_q[ADDR_W-1:0]] <= val_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign sts_o.lo_lt_hi   = (lo_q < hi_q);
  assign sts_o.idx_lt_cnt = (lo_q < cnt_q);
  assign sts_o.idx_nz     = (lo_q != '0);
  assign sts_o.rd_eq      = (rdata_q == val_q);
  assign sts_o.rd_below   = ($signed(rdata_q) < $signed(val_q));
  assign sts_o.slot_free  = !out_valid_q || m_ready_i;

  always_comb begin
    cnt_d    = cnt_q;
    sorted_d = sorted_q;
    if (cmd_i.clear) begin
      cnt_d    = '0;
      sorted_d = 1'b1;
    end else if (cmd_i.do_append && !full) begin
      cnt_d = cnt_q + CNT_W'(1);
      if ((cnt_q != '0) && ($signed(val_q) < $signed(last_q))) begin
        sorted_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_append || cmd_i.load_query) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sorted_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      sorted_q    <= sorted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // search window and partial result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      val_q <= s_value_i;
    end
    if (cmd_i.do_append && !full) begin
      last_q <= val_q;
    end
    if (cmd_i.start) begin
      lo_q            <= '0;
      hi_q            <= cnt_q;
      lin_q           <= !sorted_q;
      res_found_q     <= 1'b0;
      res_pos_q       <= '0;
      res_lower_q     <= '0;
      res_lower_vld_q <= 1'b0;
      res_upper_q     <= '0;
      res_upper_vld_q <= 1'b0;
    end
    if (cmd_i.step) begin
      if (sts_o.rd_below) begin
        lo_q <= mid + CNT_W'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.set_found) begin
      res_found_q <= 1'b1;
      res_pos_q   <= POS_W'(pos_sum);
    end
    if (cmd_i.set_upper) begin
      res_upper_q     <= rdata_q;
      res_upper_vld_q <= 1'b1;
    end
    if (cmd_i.set_lower) begin
      res_lower_q     <= rdata_q;
      res_lower_vld_q <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_append) begin
      found_o       <= 1'b0;
      position_o    <= '0;
      lower_value_o <= '0;
      lower_valid_o <= 1'b0;
      upper_value_o <= '0;
      upper_valid_o <= 1'b0;
      overflow_o    <= full;
    end else if (cmd_i.load_query) begin
      found_o       <= res_found_q;
      position_o    <= res_pos_q;
      lower_value_o <= res_lower_q;
      lower_valid_o <= res_lower_vld_q;
      upper_value_o <= res_upper_q;
      upper_valid_o <= res_upper_vld_q;
      overflow_o    <= 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

### verif/sswn_table_checker.sv
module sswn_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,  // value
  input  logic [1:0]  s_tuser_i,  // opcode
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // found, position, lower_value, lower_valid, upper_value, upper_valid, overflow, pad
  input  logic [79:0] m_tdata_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  import sswn_pkg::*;

  typedef struct packed {
    logic             pad;
    logic             overflow;
    logic             upper_valid;
    logic [VAL_W-1:0] upper_value;
    logic             lower_valid;
    logic [VAL_W-1:0] lower_value;
    logic [POS_W-1:0] position;
    logic             found;
  } lookup_result_t;

  logic [VAL_W-1:0] entry_mem [TABLE_DEPTH];
  int unsigned      entry_count;
  lookup_result_t   expected_results [$];

  function automatic bit table_step(input logic [1:0] op, input logic [VAL_W-1:0] val,
                                    output lookup_result_t res);
    int unsigned idx;
    bit          decided;
    res     = '0;
    decided = 1'b0;
    if (op == OP_CLEAR) begin
      entry_count = 0;
      return 1'b0;
    end
    if (op == OP_APPEND) begin
      if (entry_count < TABLE_DEPTH) begin
        entry_mem[entry_count] = val;
        entry_count++;
      end else begin
        res.overflow = 1'b1;
      end
      return 1'b1;
    end
    if (op != OP_QUERY) return 1'b0;
    // load-order scan: the first entry not below the value decides
    for (idx = 0; idx < entry_count && !decided; idx++) begin
      if (entry_mem[idx] == val) begin
        res.found    = 1'b1;
        res.position = POS_W'(idx + 1);
        decided      = 1'b1;
      end else if ($signed(val) < $signed(entry_mem[idx])) begin
        res.upper_value = entry_mem[idx];
        res.upper_valid = 1'b1;
        if (idx > 0) begin
          res.lower_value = entry_mem[idx-1];
          res.lower_valid = 1'b1;
        end
        decided = 1'b1;
      end
    end
    if (!decided && entry_count > 0) begin
      res.lower_value = entry_mem[entry_count-1];
      res.lower_valid = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t got;
    lookup_result_t want;
    lookup_result_t predicted;
    if (!rst_ni) begin
      entry_count  = 0;
      expected_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // an output transaction in this cycle always belongs to an earlier input
      if (m_tvalid_i && m_tready_i) begin
        got = lookup_result_t'(m_tdata_i);
        if (expected_results.size() == 0) begin
          report($sformatf("result %h with nothing expected", m_tdata_i));
        end else begin
          want = expected_results.pop_front();
          check_field("found", got.found, want.found);
          check_field("position", got.position, want.position);
          check_field("lower_value", got.lower_value, want.lower_value);
          check_field("lower_valid", got.lower_valid, want.lower_valid);
          check_field("upper_value", got.upper_value, want.upper_value);
          check_field("upper_valid", got.upper_valid, want.upper_valid);
          check_field("overflow", got.overflow, want.overflow);
          check_field("pad", got.pad, want.pad);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (table_step(s_tuser_i, s_tdata_i, predicted)) expected_results.push_back(predicted);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### verif/tb.sv
module tb;
  import sswn_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_e;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  int unsigned mismatches;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned sent_items  = 0;
  int unsigned burst_left  = 0;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;
  logic [31:0] loaded_q [$];

  always #10 clk_i = ~clk_i;

  sorted_search_with_neighbors_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  sswn_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side stall patterns
  initial begin
    rx_mode_e    rx_mode;
    int unsigned phase_left;
    int unsigned stall_left;
    int unsigned rx_tick;
    logic        rdy;
    rx_mode    = RX_OPEN;
    phase_left = 0;
    stall_left = 0;
    rx_tick    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (phase_left == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 300);
      end
      phase_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     rdy = 1'b1;
        RX_COIN:     rdy = 1'($urandom_range(0, 1));
        RX_PERIODIC: rdy = (rx_tick % 7) >= 3;
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 20);
            rdy        = 1'b0;
          end else begin
            rdy = 1'b1;
          end
        end
      endcase
      m_tready <= rdy;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    burst_left--;
    if (op != OP_UNUSED) sent_items++;
  endtask

  task automatic append_entry(input logic [31:0] val);
    send_item(OP_APPEND, val);
    if (loaded_q.size() < TABLE_DEPTH) loaded_q.push_back(val);
  endtask

  task automatic clear_table();
    send_item(OP_CLEAR, $urandom);
    loaded_q.delete();
  endtask

  function automatic logic [31:0] pick_query();
    logic [31:0] base;
    if (loaded_q.size() == 0 || $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return $urandom;
      endcase
    end
    base = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
    case ($urandom_range(0, 3))
      0, 1:    return base;
      2:       return base - 32'd1;
      default: return base + 32'd1;
    endcase
  endfunction

  initial begin
    int unsigned n_entries;
    int unsigned n_queries;
    int unsigned step_max;
    int unsigned random_start;
    longint      cur;
    bit          ascending;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, ignored opcode, extremes, duplicates
    send_item(OP_QUERY, 32'd0);
    send_item(OP_QUERY, VAL_MIN);
    send_item(OP_UNUSED, 32'hffff_ffff);
    append_entry(VAL_MIN);
    append_entry(-32'sd5);
    append_entry(-32'sd5);
    append_entry(32'd0);
    append_entry(32'd7);
    append_entry(VAL_MAX);
    send_item(OP_QUERY, VAL_MIN);
    send_item(OP_QUERY, -32'sd5);
    send_item(OP_QUERY, -32'sd6);
    send_item(OP_QUERY, 32'd3);
    send_item(OP_QUERY, VAL_MAX);
    send_item(OP_QUERY, VAL_MAX - 32'd1);
    send_item(OP_UNUSED, 32'd0);
    clear_table();
    send_item(OP_QUERY, 32'd5);
    // out of order table
    append_entry(32'd10);
    append_entry(-32'sd3);
    append_entry(32'd20);
    send_item(OP_QUERY, 32'd0);
    send_item(OP_QUERY, 32'd15);
    send_item(OP_QUERY, 32'd30);
    clear_table();

    // full table and overflow
    cur = longint'($signed(VAL_MIN));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1 || cur > longint'($signed(VAL_MAX))) append_entry(VAL_MAX);
      else append_entry(32'(cur));
      cur += longint'($urandom_range(0, 32'd1 << 22));
    end
    append_entry($urandom);
    repeat (6) send_item(OP_QUERY, pick_query());
    send_item(OP_QUERY, VAL_MAX);
    append_entry(VAL_MIN);
    send_item(OP_QUERY, VAL_MIN);
    send_item(OP_QUERY, VAL_MIN + 32'd1);
    send_item(OP_UNUSED, $urandom);
    clear_table();

    random_start = sent_items;
    hold_req     = 1'b1;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        clear_table();
        n_entries = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        ascending = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 2))
          0:       cur = longint'($signed(VAL_MIN));
          1:       cur = longint'($signed($urandom));
          default: cur = longint'($urandom_range(0, 200)) - 100;
        endcase
        case ($urandom_range(0, 2))
          0:       step_max = 3;
          1:       step_max = 65536;
          default: step_max = 32'd1 << 26;
        endcase
        for (int i = 0; i < n_entries; i++) begin
          if (ascending) begin
            if (cur > longint'($signed(VAL_MAX))) append_entry(VAL_MAX);
            else append_entry(32'(cur));
            cur += longint'($urandom_range(0, step_max));
          end else if ($urandom_range(0, 1) == 0) begin
            append_entry($urandom);
          end else begin
            append_entry(32'($urandom_range(0, 40)) - 32'd20);
          end
        end
        n_queries = $urandom_range(1, 12);
        repeat (n_queries) begin
          if ($urandom_range(0, 15) == 0) send_item(OP_UNUSED, $urandom);
          send_item(OP_QUERY, pick_query());
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 5))
            0:       clear_table();
            1, 2:    append_entry($urandom);
            3, 4:    send_item(OP_QUERY, pick_query());
            default: send_item(OP_UNUSED, $urandom);
          endcase
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
